FILE: src/pdss_pkg.sv
// shared constants and codes for the pair distance score statistics block
package pdss_pkg;

  // default sizes of the atom store
  localparam int DEF_ATOMS     = 1024;
  localparam int DEF_MAX_PAIRS = 256;

  // field widths
  localparam int COORD_W = 20;
  localparam int IDX_W   = 10;
  localparam int FUNC_W  = 2;
  localparam int SCORE_W = 17;
  localparam int FRAC_W  = 16;

  // distance arithmetic widths
  localparam int DIFF_W     = COORD_W + 1;
  localparam int SQ_OP_W    = 23;
  localparam int DIST_SQ_W  = 44;
  localparam int Q_W        = 2 * SQ_OP_W;
  localparam int DIV_NUM_W  = 47;

  // score numerator, one in Q0.16 scaled by the Q.8 distance square
  localparam logic [36:0] SCORE_NUM = 37'h10_0000_0000;
  localparam logic [SQ_OP_W-1:0] DIST_BIAS = SQ_OP_W'(1024);

  // item codes
  localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // configuration port
  localparam int CFG_AW = 1;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-1:0] REG_SPREAD = 1'b0;

endpackage

FILE: src/pdss_sqrt.sv
// bit-serial integer square root, two radicand bits per cycle
module pdss_sqrt import pdss_pkg::*; #(
  parameter int RW = DIST_SQ_W
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            go,
  input  logic [RW-1:0]   radicand,
  output logic            done,
  output logic [RW/2-1:0] root
);
  localparam int HW  = RW / 2;
  localparam int ITW = $clog2(HW + 1);

  logic [RW-1:0]  op_r;
  logic [RW-1:0]  res_r;
  logic [RW-1:0]  one_r;
  logic [RW-1:0]  trial;
  logic [ITW-1:0] cnt_r;
  logic           run_r;
  logic           done_r;

  assign trial = res_r + one_r;

  // one result bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        op_r  <= radicand;
        res_r <= '0;
        one_r <= {2'b01, {(RW-2){1'b0}}};
        cnt_r <= ITW'(HW - 1);
        run_r <= 1'b1;
      end else if (run_r) begin
        if (op_r >= trial) begin
          op_r  <= op_r - trial;
          res_r <= (res_r >> 1) + one_r;
        end else begin
          res_r <= res_r >> 1;
        end
        one_r <= one_r >> 2;
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = res_r[HW-1:0];

endmodule

FILE: src/pdss_div.sv
// restoring divider, one quotient bit per cycle
module pdss_div import pdss_pkg::*; #(
  parameter int NW  = DIV_NUM_W,
  parameter int DVW = Q_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic [NW-1:0]      dividend,
  input  logic [DVW-1:0]     divisor,
  output logic               done,
  output logic [SCORE_W-1:0] quotient
);
  localparam int CMPW = (NW > DVW + SCORE_W - 1) ? NW : DVW + SCORE_W - 1;
  localparam int ITW  = $clog2(SCORE_W + 1);

  logic [CMPW-1:0]    rem_r;
  logic [CMPW-1:0]    dsh_r;
  logic [SCORE_W-1:0] q_r;
  logic [ITW-1:0]     cnt_r;
  logic               run_r;
  logic               done_r;
  logic               ge;

  assign ge = rem_r >= dsh_r;

  // shifted divisor walks down one place a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        rem_r <= {{(CMPW-NW){1'b0}}, dividend};
        dsh_r <= {{(CMPW-DVW){1'b0}}, divisor} << (SCORE_W - 1);
        q_r   <= '0;
        cnt_r <= ITW'(SCORE_W - 1);
        run_r <= 1'b1;
      end else if (run_r) begin
        if (ge) begin
          rem_r <= rem_r - dsh_r;
        end
        q_r   <= {q_r[SCORE_W-2:0], ge};
        dsh_r <= dsh_r >> 1;
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

FILE: src/pdss_mul.sv
// shift-add multiplier, one multiplier bit per cycle
module pdss_mul import pdss_pkg::*; #(
  parameter int MCW = 41,
  parameter int MPW = 25,
  parameter int PW  = 50
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           go,
  input  logic [MCW-1:0] mcand,
  input  logic [MPW-1:0] mplier,
  output logic           done,
  output logic [PW-1:0]  product
);
  localparam int ITW = $clog2(MPW + 1);

  logic [PW-1:0]  acc_r;
  logic [PW-1:0]  mc_r;
  logic [MPW-1:0] mp_r;
  logic [ITW-1:0] cnt_r;
  logic           run_r;
  logic           done_r;

  // add the shifted multiplicand for each set multiplier bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        acc_r <= '0;
        mc_r  <= {{(PW-MCW){1'b0}}, mcand};
        mp_r  <= mplier;
        cnt_r <= ITW'(MPW - 1);
        run_r <= 1'b1;
      end else if (run_r) begin
        if (mp_r[0]) begin
          acc_r <= acc_r + mc_r;
        end
        mc_r <= mc_r << 1;
        mp_r <= mp_r >> 1;
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

FILE: src/pair_distance_score_stats_core.sv
// top level: atom store, item sequencer and configuration port
//
// Per-atom statistics of a distance score 1/(1+d/4)^2 between two 3-D points.
// Items enter on start while busy is low: func add (0), query (1), clear (2).
// Only a query gives a result: out_valid is high for exactly one cycle with
// out_result_atom, out_score_value, out_no_samples and out_count_full; the
// receiver must take it then, it cannot stall the block.
// One item is handled at a time; busy stays high until it is finished, and
// the next item is taken on start while busy is low. How long an item keeps
// busy high is set by its iterative units, with the radicand width 50 and
// the store sum width 25 by default:
//   add by the serial square root and divider
//   query mean by the 17-step divider
//   query deviation by the serial multiplier (used twice), root and divider
//   query of an atom with no pairs, clear, unused codes and ignored adds use
//   no unit; a query result is out in its last busy cycle
// Reset clears report_spread and then sweeps the store one entry a cycle with
// busy high until every entry is cleared; register writes are taken during
// the sweep. report_spread is written over the APB-style port at address 0.
module pair_distance_score_stats_core import pdss_pkg::*; #(
  parameter int ATOMS     = DEF_ATOMS,
  parameter int MAX_PAIRS = DEF_MAX_PAIRS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [FUNC_W-1:0]         in_func,
  input  logic [IDX_W-1:0]          in_atom_index,
  input  logic signed [COORD_W-1:0] in_first_x,
  input  logic signed [COORD_W-1:0] in_first_y,
  input  logic signed [COORD_W-1:0] in_first_z,
  input  logic signed [COORD_W-1:0] in_second_x,
  input  logic signed [COORD_W-1:0] in_second_y,
  input  logic signed [COORD_W-1:0] in_second_z,
  output logic                      out_valid,
  output logic [IDX_W-1:0]          out_result_atom,
  output logic [SCORE_W-1:0]        out_score_value,
  output logic                      out_no_samples,
  output logic                      out_count_full,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [CFG_AW-1:0]         paddr,
  input  logic [CFG_DW-1:0]         pwdata,
  output logic [CFG_DW-1:0]         prdata,
  output logic                      pready
);
  localparam int AW   = (ATOMS > 1) ? $clog2(ATOMS) : 1;
  localparam int CW   = $clog2(MAX_PAIRS + 1);
  localparam int SW   = CW + FRAC_W;
  localparam int SQW  = CW + 2 * FRAC_W;
  localparam int PW   = 2 * CW + 2 * FRAC_W;
  localparam int RW   = (PW > DIST_SQ_W) ? PW : DIST_SQ_W;
  localparam int RTW  = RW / 2;
  localparam int NW0  = (SW + 1 > DIV_NUM_W) ? SW + 1 : DIV_NUM_W;
  localparam int NW   = (RTW > NW0) ? RTW : NW0;
  localparam int DVW  = Q_W;

  typedef struct packed {
    logic [SW-1:0]  sum;
    logic [SQW-1:0] sq;
    logic [CW-1:0]  cnt;
  } entry_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_DECIDE, ST_SQ, ST_ROOT, ST_QSQ, ST_QDIV,
    ST_SCORE, ST_SCSQ, ST_WRITE, ST_MULA, ST_MULB, ST_DEV, ST_DIVQ, ST_OUT
  } state_t;

  state_t state_r;

  // item registers
  logic [FUNC_W-1:0]         func_r;
  logic [IDX_W-1:0]          atom_r;
  logic [AW-1:0]             addr_r;
  logic                      inside_r;
  logic signed [COORD_W-1:0] first_r  [3];
  logic signed [COORD_W-1:0] second_r [3];
  logic [1:0]                sel_r;
  logic [DIST_SQ_W-1:0]      s_r;
  logic [SQ_OP_W-1:0]        dist_r;
  logic [SCORE_W-1:0]        score_r;
  logic [CW-1:0]             n_r;
  logic [PW-1:0]             a_r;
  logic [AW-1:0]             clr_r;
  logic                      spread_r;

  // result registers
  logic [SCORE_W-1:0] val_r;
  logic               ns_r;
  logic               full_r;

  // unit launch registers
  logic             sqrt_go_r;
  logic [RW-1:0]    sqrt_in_r;
  logic             div_go_r;
  logic [NW-1:0]    div_num_r;
  logic [DVW-1:0]   div_den_r;
  logic             mul_go_r;
  logic [SQW-1:0]   mul_mc_r;
  logic [SW-1:0]    mul_mp_r;

  logic               sqrt_done;
  logic [RTW-1:0]     sqrt_root;
  logic               div_done;
  logic [SCORE_W-1:0] div_q;
  logic               mul_done;
  logic [PW-1:0]      mul_prod;

  // store
  entry_t mem [ATOMS];
  entry_t rd_r;
  entry_t wr_data;
  logic [AW-1:0] wr_addr;
  logic          wr_en;

  // distance square path
  logic signed [COORD_W-1:0] fa;
  logic signed [COORD_W-1:0] fb;
  logic [DIFF_W-1:0]         diff;
  logic [DIFF_W-1:0]         mag;
  logic [SQ_OP_W-1:0]        sq_op;
  logic [Q_W-1:0]            mul_p_r;
  logic [DIST_SQ_W-1:0]      s_sum;

  logic [31:0]   atom_ext;
  logic [CW-1:0] n_q;
  logic [PW-1:0] x_dev;
  logic          cfg_wr;

  assign atom_ext = 32'(in_atom_index);
  assign n_q      = inside_r ? rd_r.cnt : '0;
  assign x_dev    = (a_r > mul_prod) ? a_r - mul_prod : '0;
  assign s_sum    = s_r + mul_p_r[DIST_SQ_W-1:0];

  // coordinate pick for the current axis
  always_comb begin
    case (sel_r)
      2'd0: begin
        fa = first_r[0];
        fb = second_r[0];
      end
      2'd1: begin
        fa = first_r[1];
        fb = second_r[1];
      end
      2'd2: begin
        fa = first_r[2];
        fb = second_r[2];
      end
      default: begin
        fa = '0;
        fb = '0;
      end
    endcase
  end

  assign diff = {fa[COORD_W-1], fa} - {fb[COORD_W-1], fb};
  assign mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : diff;

  // shared squarer operand
  always_comb begin
    case (state_r)
      ST_SQ:   sq_op = SQ_OP_W'(mag);
      ST_QSQ:  sq_op = dist_r + DIST_BIAS;
      ST_SCSQ: sq_op = SQ_OP_W'(score_r);
      default: sq_op = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p_r <= sq_op * sq_op;
  end

  // store write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr_r;
    wr_data = '0;
    if (state_r == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_r;
    end else if (state_r == ST_WRITE) begin
      wr_en = 1'b1;
      if (func_r == FUNC_ADD) begin
        wr_data.sum = rd_r.sum + SW'(score_r);
        wr_data.sq  = rd_r.sq + SQW'(mul_p_r[2*FRAC_W:0]);
        wr_data.cnt = rd_r.cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_r <= mem[addr_r];
  end

  // configuration port
  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;
  assign prdata = (paddr == REG_SPREAD) ? CFG_DW'(spread_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spread_r <= 1'b0;
    end else if (cfg_wr && paddr == REG_SPREAD) begin
      spread_r <= pwdata[0];
    end
  end

  // item sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_r     <= '0;
      sqrt_go_r <= 1'b0;
      div_go_r  <= 1'b0;
      mul_go_r  <= 1'b0;
    end else begin
      sqrt_go_r <= 1'b0;
      div_go_r  <= 1'b0;
      mul_go_r  <= 1'b0;
      unique case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(ATOMS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            func_r      <= in_func;
            atom_r      <= in_atom_index;
            addr_r      <= atom_ext[AW-1:0];
            inside_r    <= atom_ext < 32'(ATOMS);
            first_r[0]  <= in_first_x;
            first_r[1]  <= in_first_y;
            first_r[2]  <= in_first_z;
            second_r[0] <= in_second_x;
            second_r[1] <= in_second_y;
            second_r[2] <= in_second_z;
            state_r     <= ST_READ;
          end
        end
        ST_READ: begin
          state_r <= ST_DECIDE;
        end
        ST_DECIDE: begin
          case (func_r)
            FUNC_ADD: begin
              if (!inside_r || rd_r.cnt >= CW'(MAX_PAIRS)) begin
                state_r <= ST_IDLE;
              end else begin
                sel_r   <= 2'd0;
                s_r     <= '0;
                state_r <= ST_SQ;
              end
            end
            FUNC_CLEAR: begin
              state_r <= inside_r ? ST_WRITE : ST_IDLE;
            end
            FUNC_QUERY: begin
              n_r    <= n_q;
              full_r <= n_q >= CW'(MAX_PAIRS);
              ns_r   <= 1'b0;
              if (n_q == '0) begin
                val_r   <= '0;
                ns_r    <= 1'b1;
                full_r  <= 1'b0;
                state_r <= ST_OUT;
              end else if (spread_r) begin
                mul_go_r <= 1'b1;
                mul_mc_r <= rd_r.sq;
                mul_mp_r <= SW'(n_q);
                state_r  <= ST_MULA;
              end else begin
                div_go_r  <= 1'b1;
                div_num_r <= NW'(rd_r.sum) + NW'(n_q >> 1);
                div_den_r <= DVW'(n_q);
                state_r   <= ST_DIVQ;
              end
            end
            default: state_r <= ST_IDLE;
          endcase
        end
        ST_SQ: begin
          sel_r <= sel_r + 1'b1;
          if (sel_r != 2'd0) begin
            s_r <= s_sum;
          end
          if (sel_r == 2'd3) begin
            sqrt_go_r <= 1'b1;
            sqrt_in_r <= RW'(s_sum);
            state_r   <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (sqrt_done) begin
            dist_r  <= SQ_OP_W'(sqrt_root);
            state_r <= ST_QSQ;
          end
        end
        ST_QSQ: begin
          state_r <= ST_QDIV;
        end
        ST_QDIV: begin
          div_go_r  <= 1'b1;
          div_num_r <= NW'(SCORE_NUM) + NW'(mul_p_r >> 1);
          div_den_r <= mul_p_r;
          state_r   <= ST_SCORE;
        end
        ST_SCORE: begin
          if (div_done) begin
            score_r <= div_q;
            state_r <= ST_SCSQ;
          end
        end
        ST_SCSQ: begin
          state_r <= ST_WRITE;
        end
        ST_WRITE: begin
          state_r <= ST_IDLE;
        end
        ST_MULA: begin
          if (mul_done) begin
            a_r      <= mul_prod;
            mul_go_r <= 1'b1;
            mul_mc_r <= SQW'(rd_r.sum);
            mul_mp_r <= rd_r.sum;
            state_r  <= ST_MULB;
          end
        end
        ST_MULB: begin
          if (mul_done) begin
            sqrt_go_r <= 1'b1;
            sqrt_in_r <= RW'(x_dev);
            state_r   <= ST_DEV;
          end
        end
        ST_DEV: begin
          if (sqrt_done) begin
            div_go_r  <= 1'b1;
            div_num_r <= NW'(sqrt_root);
            div_den_r <= DVW'(n_r);
            state_r   <= ST_DIVQ;
          end
        end
        ST_DIVQ: begin
          if (div_done) begin
            val_r   <= div_q;
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy            = state_r != ST_IDLE;
  assign out_valid       = state_r == ST_OUT;
  assign out_result_atom = atom_r;
  assign out_score_value = val_r;
  assign out_no_samples  = ns_r;
  assign out_count_full  = full_r;

  // iterative units
  pdss_sqrt #(
    .RW (RW)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (sqrt_go_r),
    .radicand (sqrt_in_r),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  pdss_div #(
    .NW  (NW),
    .DVW (DVW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go_r),
    .dividend (div_num_r),
    .divisor  (div_den_r),
    .done     (div_done),
    .quotient (div_q)
  );

  pdss_mul #(
    .MCW (SQW),
    .MPW (SW),
    .PW  (PW)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (mul_go_r),
    .mcand   (mul_mc_r),
    .mplier  (mul_mp_r),
    .done    (mul_done),
    .product (mul_prod)
  );

endmodule
